FILE: hw/rtl/piu_pkg.sv
package piu_pkg;

	// fixed widths of the stream payload
	localparam int unsigned DATA_W      = 32;
	localparam int unsigned YAW_W       = 19;
	localparam int unsigned IN_TDATA_W  = 88;
	localparam int unsigned OUT_TDATA_W = 96;
	localparam int unsigned OUT_TUSER_W = 1;

	// filter shape and coefficient format (Q2.COEF_FRAC_BITS)
	localparam int unsigned FILTER_ORDER   = 4;
	localparam int unsigned NUM_TAPS       = 2 * FILTER_ORDER + 1;
	localparam int unsigned NUM_CH         = 3;
	localparam int unsigned COEF_FRAC_BITS = 16;
	localparam int unsigned COEF_W         = COEF_FRAC_BITS + 2;
	localparam int unsigned PROD_W         = DATA_W + COEF_W;
	localparam int unsigned ACC_W          = PROD_W + 4;
	localparam int unsigned RND_W          = ACC_W - COEF_FRAC_BITS;

	// coefficient magnitudes, rounded to nearest with halves away from zero
	localparam longint COEF_B0 = ((longint'(2) <<< COEF_FRAC_BITS) * 2 + 100) / 200;
	localparam longint COEF_B1 = ((longint'(82) <<< COEF_FRAC_BITS) * 2 + 1000) / 2000;
	localparam longint COEF_B2 = ((longint'(12) <<< COEF_FRAC_BITS) * 2 + 100) / 200;
	localparam longint COEF_A1 = ((longint'(15) <<< COEF_FRAC_BITS) * 2 + 10) / 20;
	localparam longint COEF_A2 = ((longint'(12) <<< COEF_FRAC_BITS) * 2 + 10) / 20;
	localparam longint COEF_A3 = ((longint'(45) <<< COEF_FRAC_BITS) * 2 + 100) / 200;
	localparam longint COEF_A4 = ((longint'(7) <<< COEF_FRAC_BITS) * 2 + 100) / 200;

	// heading constants, Q16.16
	localparam logic signed [21:0] PI_Q16     = 22'sd205887;
	localparam logic signed [21:0] TWO_PI_Q16 = 22'sd411775;

	typedef logic [3:0] tap_t;
	typedef logic [1:0] chan_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UNWRAP,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND,
		ST_OUT
	} state_t;

	// signed coefficient per tap: tap 0..4 feed-forward, 5..8 feedback (sign folded in)
	function automatic logic signed [COEF_W-1:0] coef_tap(input tap_t tap);
		logic signed [COEF_W-1:0] c;
		unique case (tap)
			4'd0:    c = COEF_W'(COEF_B0);
			4'd1:    c = COEF_W'(COEF_B1);
			4'd2:    c = COEF_W'(COEF_B2);
			4'd3:    c = COEF_W'(COEF_B1);
			4'd4:    c = COEF_W'(COEF_B0);
			4'd5:    c = COEF_W'(COEF_A1);
			4'd6:    c = COEF_W'(-COEF_A2);
			4'd7:    c = COEF_W'(COEF_A3);
			4'd8:    c = COEF_W'(-COEF_A4);
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

FILE: hw/rtl/pose_iir_lowpass_unwrap_core.sv
// channel | dir | handshake          | payload (low bit first)
// s_      | in  | s_tvalid/s_tready  | tdata: pos_x[31:0], pos_y[31:0], yaw[18:0], zero pad
// m_      | out | m_tvalid/m_tready  | tdata: filt_x, filt_y, filt_heading; tuser: saturated
//
// one item runs through accept, heading unwrap, then 3 channels x (9 products,
// one drain, one round), then the output load; the single shared multiplier does
// all 27 products.
// arst_n clears filter histories, heading state and the output valid.
// a finished result waits in the output register while the next item is taken;
// the sequencer only holds in its last state when that register is still full.
module pose_iir_lowpass_unwrap_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [piu_pkg::IN_TDATA_W-1:0]         s_tdata,  // pos_x, pos_y, yaw, pad
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [piu_pkg::OUT_TDATA_W-1:0]        m_tdata,  // filt_x, filt_y, filt_heading
	output logic [piu_pkg::OUT_TUSER_W-1:0]        m_tuser   // saturated
);

	piu_pkg::state_t state_q, state_d;

	// control outputs of the sequencer
	logic in_take;
	logic do_unwrap;
	logic do_issue;
	logic do_drain;
	logic do_round;
	logic do_out;
	logic last_tap;
	logic last_ch;

	// sequence counters
	piu_pkg::tap_t  tap_q;
	piu_pkg::chan_t ch_q;

	// item registers
	logic signed [piu_pkg::DATA_W-1:0] px_q, py_q;
	logic signed [piu_pkg::YAW_W-1:0]  yaw_q;

	// heading state
	logic signed [piu_pkg::YAW_W-1:0]  prev_yaw_q;
	logic signed [piu_pkg::DATA_W-1:0] unwrapped_q;
	logic                              first_q;
	logic                              flag_q;

	// filter histories, newest first
	logic signed [piu_pkg::DATA_W-1:0] hin_q  [piu_pkg::NUM_CH][piu_pkg::FILTER_ORDER];
	logic signed [piu_pkg::DATA_W-1:0] hout_q [piu_pkg::NUM_CH][piu_pkg::FILTER_ORDER];

	// mac datapath
	logic signed [piu_pkg::PROD_W-1:0] prod_s1;
	logic signed [piu_pkg::ACC_W-1:0]  acc_q;
	logic signed [piu_pkg::DATA_W-1:0] res_q [piu_pkg::NUM_CH];

	// output register
	logic                              m_valid_q;
	logic [piu_pkg::OUT_TDATA_W-1:0]   m_data_q;
	logic                              m_sat_q;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_sat_q;

	assign last_tap = (tap_q == piu_pkg::tap_t'(piu_pkg::NUM_TAPS - 1));
	assign last_ch  = (ch_q == piu_pkg::chan_t'(piu_pkg::NUM_CH - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			piu_pkg::ST_IDLE:   if (s_tvalid) state_d = piu_pkg::ST_UNWRAP;
			piu_pkg::ST_UNWRAP: state_d = piu_pkg::ST_MAC;
			piu_pkg::ST_MAC:    if (last_tap) state_d = piu_pkg::ST_DRAIN;
			piu_pkg::ST_DRAIN:  state_d = piu_pkg::ST_ROUND;
			piu_pkg::ST_ROUND:  state_d = last_ch ? piu_pkg::ST_OUT : piu_pkg::ST_MAC;
			piu_pkg::ST_OUT:    if (!m_valid_q || m_tready) state_d = piu_pkg::ST_IDLE;
			default:            state_d = piu_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		do_unwrap = 1'b0;
		do_issue  = 1'b0;
		do_drain  = 1'b0;
		do_round  = 1'b0;
		do_out    = 1'b0;
		unique case (state_q)
			piu_pkg::ST_IDLE:   s_tready  = 1'b1;
			piu_pkg::ST_UNWRAP: do_unwrap = 1'b1;
			piu_pkg::ST_MAC:    do_issue  = 1'b1;
			piu_pkg::ST_DRAIN:  do_drain  = 1'b1;
			piu_pkg::ST_ROUND:  do_round  = 1'b1;
			piu_pkg::ST_OUT:    do_out    = !m_valid_q || m_tready;
			default:            s_tready  = 1'b0;
		endcase
	end

	assign in_take = s_tvalid && s_tready;

	// heading unwrap: one correction of the step by 2*pi
	logic signed [21:0] step_raw, step_fix;
	logic signed [32:0] head_sum;
	logic signed [piu_pkg::DATA_W-1:0] head_next;
	logic head_sat;

	always_comb begin
		step_raw = 22'(yaw_q) - 22'(prev_yaw_q);
		if (step_raw >= piu_pkg::PI_Q16)
			step_fix = step_raw - piu_pkg::TWO_PI_Q16;
		else if (step_raw < -piu_pkg::PI_Q16)
			step_fix = step_raw + piu_pkg::TWO_PI_Q16;
		else
			step_fix = step_raw;
		head_sum = 33'(unwrapped_q) + 33'(step_fix);
		head_sat = 1'b0;
		if (first_q) begin
			head_next = piu_pkg::DATA_W'(yaw_q);
		end else if (head_sum[32] != head_sum[31]) begin
			head_sat  = 1'b1;
			head_next = head_sum[32] ? {1'b1, {(piu_pkg::DATA_W-1){1'b0}}}
			                         : {1'b0, {(piu_pkg::DATA_W-1){1'b1}}};
		end else begin
			head_next = head_sum[31:0];
		end
	end

	// operand for the current tap
	logic signed [piu_pkg::DATA_W-1:0] cur_in;
	logic signed [piu_pkg::DATA_W-1:0] opnd;
	piu_pkg::tap_t tap_in, tap_out;

	always_comb begin
		tap_in  = tap_q - 4'd1;
		tap_out = tap_q - 4'd5;
		case (ch_q)
			2'd0:    cur_in = px_q;
			2'd1:    cur_in = py_q;
			default: cur_in = unwrapped_q;
		endcase
		if (tap_q == 4'd0)
			opnd = cur_in;
		else if (tap_q <= 4'd4)
			opnd = hin_q[ch_q][tap_in[1:0]];
		else
			opnd = hout_q[ch_q][tap_out[1:0]];
	end

	// rounding to Q16.16 with halves up, then clipping to 32 bits
	logic signed [piu_pkg::ACC_W-1:0] acc_rnd;
	logic signed [piu_pkg::RND_W-1:0] acc_shr;
	logic signed [piu_pkg::DATA_W-1:0] filt_res;
	logic filt_sat;

	always_comb begin
		acc_rnd = acc_q + (piu_pkg::ACC_W'(1) <<< (piu_pkg::COEF_FRAC_BITS - 1));
		acc_shr = piu_pkg::RND_W'(acc_rnd >>> piu_pkg::COEF_FRAC_BITS);
		filt_sat = !((&acc_shr[piu_pkg::RND_W-1:piu_pkg::DATA_W-1]) ||
		             !(|acc_shr[piu_pkg::RND_W-1:piu_pkg::DATA_W-1]));
		if (!filt_sat)
			filt_res = acc_shr[piu_pkg::DATA_W-1:0];
		else if (acc_shr[piu_pkg::RND_W-1])
			filt_res = {1'b1, {(piu_pkg::DATA_W-1){1'b0}}};
		else
			filt_res = {1'b0, {(piu_pkg::DATA_W-1){1'b1}}};
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= piu_pkg::ST_IDLE;
			tap_q       <= '0;
			ch_q        <= '0;
			prev_yaw_q  <= '0;
			unwrapped_q <= '0;
			first_q     <= 1'b1;
			flag_q      <= 1'b0;
			m_valid_q   <= 1'b0;
			for (int c = 0; c < piu_pkg::NUM_CH; c++) begin
				for (int k = 0; k < piu_pkg::FILTER_ORDER; k++) begin
					hin_q[c][k]  <= '0;
					hout_q[c][k] <= '0;
				end
			end
		end else begin
			state_q <= state_d;

			// heading update and flag restart
			if (do_unwrap) begin
				unwrapped_q <= head_next;
				prev_yaw_q  <= yaw_q;
				first_q     <= 1'b0;
				flag_q      <= head_sat;
				tap_q       <= '0;
				ch_q        <= '0;
			end

			// tap counter
			if (do_issue)
				tap_q <= last_tap ? '0 : tap_q + 4'd1;

			// channel finish: shift histories
			if (do_round) begin
				flag_q <= flag_q | filt_sat;
				for (int k = piu_pkg::FILTER_ORDER - 1; k > 0; k--) begin
					hin_q[ch_q][k]  <= hin_q[ch_q][k-1];
					hout_q[ch_q][k] <= hout_q[ch_q][k-1];
				end
				hin_q[ch_q][0]  <= cur_in;
				hout_q[ch_q][0] <= filt_res;
				ch_q            <= last_ch ? '0 : ch_q + 2'd1;
			end

			// output valid
			if (do_out)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			px_q  <= s_tdata[31:0];
			py_q  <= s_tdata[63:32];
			yaw_q <= s_tdata[82:64];
		end

		// shared multiplier, registered
		if (do_issue)
			prod_s1 <= piu_pkg::PROD_W'(opnd) * piu_pkg::PROD_W'(piu_pkg::coef_tap(tap_q));

		// accumulate the product of the previous tap
		if (do_issue) begin
			if (tap_q == 4'd0)
				acc_q <= '0;
			else
				acc_q <= acc_q + piu_pkg::ACC_W'(prod_s1);
		end else if (do_drain) begin
			acc_q <= acc_q + piu_pkg::ACC_W'(prod_s1);
		end

		if (do_round)
			res_q[ch_q] <= filt_res;

		if (do_out) begin
			m_data_q <= {res_q[2], res_q[1], res_q[0]};
			m_sat_q  <= flag_q;
		end
	end

endmodule

FILE: sim/pose_iir_lowpass_unwrap_core_tb.sv
`timescale 1ns / 100ps

module pose_iir_lowpass_unwrap_core_tb;

	localparam int FRAC        = piu_pkg::COEF_FRAC_BITS;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int TAIL_CYCLES = 120;
	localparam int PAD_W       = piu_pkg::IN_TDATA_W - 2 * piu_pkg::DATA_W - piu_pkg::YAW_W;

	// heading constants, Q16.16
	localparam longint PI_FX     = 205887;
	localparam longint TWO_PI_FX = 411775;
	localparam longint I32_MAX   = 64'sd2147483647;
	localparam longint I32_MIN   = -64'sd2147483648;

	// lowpass coefficients in Q2.FRAC, rounded half away from zero
	localparam longint CB0 = ((longint'(2) <<< FRAC) * 2 + 100) / 200;
	localparam longint CB1 = ((longint'(82) <<< FRAC) * 2 + 1000) / 2000;
	localparam longint CB2 = ((longint'(12) <<< FRAC) * 2 + 100) / 200;
	localparam longint CA1 = ((longint'(15) <<< FRAC) * 2 + 10) / 20;
	localparam longint CA2 = ((longint'(12) <<< FRAC) * 2 + 10) / 20;
	localparam longint CA3 = ((longint'(45) <<< FRAC) * 2 + 100) / 200;
	localparam longint CA4 = ((longint'(7) <<< FRAC) * 2 + 100) / 200;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		logic [31:0] px;
		logic [31:0] py;
		logic [18:0] yaw;
		idle_mode_t  mode;
		bit          hold;
	} pose_item_t;

	typedef struct {
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] fh;
		logic        sat;
	} pose_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [piu_pkg::IN_TDATA_W-1:0] s_tdata = '0;  // pos_x, pos_y, yaw, pad
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [piu_pkg::OUT_TDATA_W-1:0] m_tdata;      // filt_x, filt_y, filt_heading
	logic [piu_pkg::OUT_TUSER_W-1:0] m_tuser;      // saturated

	pose_item_t   pose_pending_q[$];
	pose_result_t pose_expect_q[$];
	idle_mode_t   cur_mode = IDLE_NONE;
	int           n_accepted = 0;
	int           n_checked = 0;
	int           err_count = 0;
	int           cycle_count = 0;
	int           gen_prev_yaw = 0;

	// predictor state: channel 0 x, 1 y, 2 heading; histories newest first
	longint hist_in [3][4];
	longint hist_out [3][4];
	longint pred_prev_yaw;
	longint pred_heading;
	bit     pred_first;

	pose_iir_lowpass_unwrap_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// clip to the signed 32-bit range
	function automatic longint clip32(longint v, inout bit clipped);
		if (v > I32_MAX) begin
			clipped = 1'b1;
			return I32_MAX;
		end
		if (v < I32_MIN) begin
			clipped = 1'b1;
			return I32_MIN;
		end
		return v;
	endfunction

	function automatic longint ff_coef(int i);
		case (i)
			0, 4:    return CB0;
			1, 3:    return CB1;
			default: return CB2;
		endcase
	endfunction

	// feedback taps carry the sign of the denominator (-1.5, 1.2, -0.45, 0.07)
	function automatic longint fb_coef(int i);
		case (i)
			0:       return -CA1;
			1:       return CA2;
			2:       return -CA3;
			default: return CA4;
		endcase
	endfunction

	// one fourth-order direct-form-I step on one channel
	function automatic longint lowpass_step(int ch, longint cur, inout bit clipped);
		longint acc;
		longint r;
		int i;
		acc = ff_coef(0) * cur;
		for (i = 1; i <= 4; i++)
			acc += ff_coef(i) * hist_in[ch][i-1] - fb_coef(i-1) * hist_out[ch][i-1];
		r = clip32((acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC, clipped);
		for (i = 3; i > 0; i--) begin
			hist_in[ch][i] = hist_in[ch][i-1];
			hist_out[ch][i] = hist_out[ch][i-1];
		end
		hist_in[ch][0] = cur;
		hist_out[ch][0] = r;
		return r;
	endfunction

	// heading unwrap followed by the three lowpass channels
	function automatic pose_result_t predict_pose(logic [31:0] px, logic [31:0] py,
			logic [18:0] yaw);
		pose_result_t res;
		bit clipped;
		longint yw;
		longint step;
		clipped = 1'b0;
		yw = longint'($signed(yaw));
		if (pred_first) begin
			pred_heading = yw;
			pred_first = 1'b0;
		end else begin
			step = yw - pred_prev_yaw;
			if (step >= PI_FX)
				step -= TWO_PI_FX;
			else if (step < -PI_FX)
				step += TWO_PI_FX;
			pred_heading = clip32(pred_heading + step, clipped);
		end
		pred_prev_yaw = yw;
		res.fx = 32'(lowpass_step(0, longint'($signed(px)), clipped));
		res.fy = 32'(lowpass_step(1, longint'($signed(py)), clipped));
		res.fh = 32'(lowpass_step(2, pred_heading, clipped));
		res.sat = clipped;
		return res;
	endfunction

	// random idle decision for one side
	function automatic bit idle_roll(idle_mode_t m, bit recv_side);
		int pct;
		pct = 0;
		if (m == IDLE_BOTH)
			pct = 17;
		else if ((m == IDLE_SEND && !recv_side) || (m == IDLE_RECV && recv_side))
			pct = 87;
		return $urandom_range(0, 99) < pct;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (err_count < 40)
			$display("mismatch in %s at result %0d: got %h, want %h",
				what, n_checked, got, want);
		err_count++;
	endtask

	task automatic add_item(input logic [31:0] px, input logic [31:0] py, input int yaw,
			input idle_mode_t mode, input bit hold);
		pose_item_t it;
		it.px = px;
		it.py = py;
		it.yaw = yaw[18:0];
		it.mode = mode;
		it.hold = hold;
		pose_pending_q.push_back(it);
		gen_prev_yaw = yaw;
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 9))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'(int'($urandom_range(0, 4000)) - 2000);
			3:       return 32'(int'($urandom_range(0, 2000000)) - 1000000);
			default: return $urandom;
		endcase
	endfunction

	// random pose with yaw steps biased toward the wrap boundaries
	task automatic gen_random(input idle_mode_t mode, input bit hold);
		int y;
		case ($urandom_range(0, 9))
			0: begin
				y = gen_prev_yaw + int'(PI_FX);
				if (y > 262143)
					y = gen_prev_yaw - int'(PI_FX);
			end
			1: begin
				y = gen_prev_yaw - int'(PI_FX);
				if (y < -262144)
					y = gen_prev_yaw + int'(PI_FX);
			end
			2: y = int'($urandom_range(0, 524287)) - 262144;
			3: begin
				y = gen_prev_yaw + int'($urandom_range(0, 200)) - 100;
				if (y > 262143 || y < -262144)
					y = 0;
			end
			default: y = int'($urandom_range(0, 411774)) - int'(PI_FX);
		endcase
		add_item(pick_coord(), pick_coord(), y, mode, hold);
	endtask

	// driver: presents pending items and predicts each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin : drv_reset
			int c;
			int k;
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			cur_mode <= IDLE_NONE;
			n_accepted <= 0;
			for (c = 0; c < 3; c++)
				for (k = 0; k < 4; k++) begin
					hist_in[c][k] = 0;
					hist_out[c][k] = 0;
				end
			pred_prev_yaw = 0;
			pred_heading = 0;
			pred_first = 1'b1;
		end else begin : drv_run
			pose_item_t it;
			bit accept_now;
			bit go;
			accept_now = s_tvalid && s_tready;
			if (accept_now) begin
				pose_expect_q.push_back(predict_pose(s_tdata[31:0], s_tdata[63:32],
					s_tdata[82:64]));
				n_accepted <= n_accepted + 1;
			end
			if (!s_tvalid || s_tready) begin
				go = pose_pending_q.size() != 0;
				if (go)
					go = !idle_roll(pose_pending_q[0].mode, 1'b0);
				// a held item waits until every result is back
				if (go && pose_pending_q[0].hold)
					go = !accept_now && (n_accepted == n_checked);
				if (go) begin
					it = pose_pending_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {{PAD_W{1'b0}}, it.yaw, it.py, it.px};
					cur_mode <= it.mode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure and field checks against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			n_checked <= 0;
		end else begin : mon_run
			pose_result_t want;
			if (m_tvalid && m_tready) begin
				if (pose_expect_q.size() == 0) begin
					report_mismatch("unexpected result", m_tdata[31:0], '0);
				end else begin
					want = pose_expect_q.pop_front();
					if (m_tdata[31:0] !== want.fx)
						report_mismatch("filt_x", m_tdata[31:0], want.fx);
					if (m_tdata[63:32] !== want.fy)
						report_mismatch("filt_y", m_tdata[63:32], want.fy);
					if (m_tdata[95:64] !== want.fh)
						report_mismatch("filt_heading", m_tdata[95:64], want.fh);
					if (m_tuser[0] !== want.sat)
						report_mismatch("saturated", 32'(m_tuser[0]), 32'(want.sat));
				end
				n_checked <= n_checked + 1;
			end
			m_tready <= !idle_roll(cur_mode, 1'b1);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int n;
		int p;
		int y;
		int step;
		idle_mode_t phase_mode [4];

		// first sample loads the heading, then the wrap boundaries
		add_item(32'h0, 32'h0, int'(PI_FX), IDLE_NONE, 1'b0);
		add_item(32'h1, 32'hffff_ffff, -int'(PI_FX), IDLE_NONE, 1'b0);
		// step of exactly pi wraps, step of exactly minus pi does not
		add_item(32'h0001_0000, 32'hffff_0000, 0, IDLE_NONE, 1'b0);
		add_item(32'h0, 32'h0, -int'(PI_FX), IDLE_NONE, 1'b0);
		// yaw beyond pi, up to the 19-bit extremes
		add_item(32'h0, 32'h0, 262143, IDLE_NONE, 1'b0);
		add_item(32'h0, 32'h0, -262144, IDLE_NONE, 1'b0);
		add_item(32'h0, 32'h0, 262143, IDLE_NONE, 1'b0);
		// full-scale steps overshoot and clip the filters
		for (n = 0; n < 6; n++)
			add_item(32'h7fff_ffff, 32'h8000_0000, 0, IDLE_NONE, 1'b0);
		for (n = 0; n < 6; n++)
			add_item(32'h8000_0000, 32'h7fff_ffff, 0, IDLE_NONE, 1'b0);
		for (n = 0; n < 4; n++)
			add_item(n[0] ? 32'h8000_0000 : 32'h7fff_ffff,
				n[0] ? 32'h7fff_ffff : 32'h8000_0000, 0, IDLE_NONE, 1'b0);
		add_item(32'h0, 32'h0, 0, IDLE_NONE, 1'b0);

		// steady rotation just under pi per item winds the heading up
		for (n = 0; n < 400; n++) begin
			step = int'(PI_FX) - 1 - int'($urandom_range(0, 48));
			y = gen_prev_yaw + step;
			if (y > int'(PI_FX))
				y -= int'(TWO_PI_FX);
			add_item(pick_coord(), pick_coord(), y, IDLE_NONE, n == 0);
		end
		// and back down a little
		for (n = 0; n < 100; n++) begin
			step = int'(PI_FX) - 1 - int'($urandom_range(0, 48));
			y = gen_prev_yaw - step;
			if (y < -int'(PI_FX))
				y += int'(TWO_PI_FX);
			add_item(pick_coord(), pick_coord(), y, IDLE_NONE, 1'b0);
		end

		// random phases, each opened after the pipeline has fully drained
		phase_mode[0] = IDLE_SEND;
		phase_mode[1] = IDLE_RECV;
		phase_mode[2] = IDLE_BOTH;
		phase_mode[3] = IDLE_NONE;
		for (p = 0; p < 4; p++)
			for (n = 0; n < 170; n++)
				gen_random(phase_mode[p], n == 0);

		// reset
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain and settle
		while (pose_pending_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (pose_expect_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: pose_iir_lowpass_unwrap_core.f
hw/rtl/piu_pkg.sv
hw/rtl/pose_iir_lowpass_unwrap_core.sv
sim/pose_iir_lowpass_unwrap_core_tb.sv
